/* hw/rtl/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg
// Types, codes and defaults shared by the bounded sorted list and its cells.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_APPEND        = 2'd0,
    OP_REMOVE_FIRST  = 2'd1,
    OP_SORTED_INSERT = 2'd2,
    OP_SORTED_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_TAIL,
    EDIT_INSERT,
    EDIT_DELETE
  } edit_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    opcode_t                    opcode;
    edit_t                      edit;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

  // Passed from each cell to the next one up the row.
  typedef struct packed {
    logic hit;      // a cell at or below this one matched the search
    logic hit_eq;   // the first matching cell holds the value exactly
    logic tail_lt;  // value is below the last held entry
    logic tail_gt;  // value is above the last held entry
  } chain_t;

endpackage

/* hw/rtl/bsl_cell.sv */
// ----------------------------------------------------------------------------
// bsl_cell
// One list slot: holds an entry, compares it against the incoming value and
// takes part in the priority chain that locates the edit position.
// ----------------------------------------------------------------------------
module bsl_cell
  import bsl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int UW  = 5
) (
  input  logic                       clk,
  input  logic                       flag_en,
  input  logic signed [VALUE_W-1:0]  cmp_value,
  input  cell_ctrl_t                 ctrl,
  input  logic [UW-1:0]              used,
  input  logic signed [VALUE_W-1:0]  left_entry,
  input  logic signed [VALUE_W-1:0]  right_entry,
  input  chain_t                     chain_in,
  output chain_t                     chain_out,
  output logic signed [VALUE_W-1:0]  entry
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      eq_r;
  logic                      lt_r;
  logic                      held;
  logic                      is_last;
  logic                      cond;
  logic                      sel;
  logic                      first;

  always_ff @(posedge clk) begin
    if (flag_en) begin
      eq_r <= (cmp_value == entry_r);
      lt_r <= (cmp_value < entry_r);
    end
    entry_r <= entry_nxt;
  end

  assign held    = (UW'(IDX) < used);
  assign is_last = held && (UW'(IDX + 1) == used);

  always_comb begin
    unique case (ctrl.opcode)
      OP_APPEND:        cond = 1'b0;
      OP_REMOVE_FIRST:  cond = eq_r;
      OP_SORTED_INSERT: cond = lt_r;
      OP_SORTED_REMOVE: cond = eq_r | lt_r;
      default:          cond = 1'b0;
    endcase
  end

  assign sel   = held && cond;
  assign first = sel && !chain_in.hit;

  always_comb begin
    chain_out.hit     = chain_in.hit | sel;
    chain_out.hit_eq  = chain_in.hit_eq | (first & eq_r);
    chain_out.tail_lt = chain_in.tail_lt | (is_last & lt_r);
    chain_out.tail_gt = chain_in.tail_gt | (is_last & !eq_r & !lt_r);
  end

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.edit)
      EDIT_NONE: begin
      end
      EDIT_TAIL: begin
        if (UW'(IDX) == used) entry_nxt = ctrl.value;
      end
      EDIT_INSERT: begin
        if (first) entry_nxt = ctrl.value;
        else if (chain_in.hit) entry_nxt = left_entry;
      end
      EDIT_DELETE: begin
        // close the gap: every slot from the match upward pulls from above
        if (chain_out.hit) entry_nxt = right_entry;
      end
      default: begin
      end
    endcase
  end

  assign entry = entry_r;

endmodule

/* hw/rtl/bounded_sorted_list.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_list
// Fixed-capacity packed list of signed 32-bit entries with append, remove
// first match, sorted insert and sorted remove.
// ----------------------------------------------------------------------------
// At the accepting edge every cell compares its entry with the value and
// registers the result; in the execute state the priority chain through the
// row of cells finds the edit position, and when the item commits every cell
// shifts one place or loads the value, and the result beat is registered. No
// new item is taken until the current one has committed; a waiting result
// delays only the commit of the next item, not its acceptance. The list holds
// up to CAPACITY entries; empty after reset.
// ----------------------------------------------------------------------------
module bounded_sorted_list
  import bsl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int UW = $clog2(CAPACITY + 1);

  state_t                    state_r;
  state_t                    state_nxt;
  opcode_t                   op_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [UW-1:0]             used_r;
  logic [UW-1:0]             used_nxt;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic                      accept;
  logic                      commit;
  logic                      ok;
  logic                      full;
  logic                      empty;
  edit_t                     edit;
  cell_ctrl_t                ctrl;

  chain_t                    chain [CAPACITY+1];
  logic signed [VALUE_W-1:0] ent   [CAPACITY];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign full     = (used_r == UW'(CAPACITY));
  assign empty    = (used_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // decide the edit from the chain results
  always_comb begin
    ok   = 1'b0;
    edit = EDIT_NONE;
    unique case (op_r)
      OP_APPEND: begin
        ok   = !full;
        edit = EDIT_TAIL;
      end
      OP_REMOVE_FIRST: begin
        ok   = chain[CAPACITY].hit;
        edit = EDIT_DELETE;
      end
      OP_SORTED_INSERT: begin
        ok = !full;
        if (empty || !chain[CAPACITY].tail_lt) edit = EDIT_TAIL;
        else edit = EDIT_INSERT;
      end
      OP_SORTED_REMOVE: begin
        // a value below the head always lands on a greater entry and fails
        ok   = !empty && !chain[CAPACITY].tail_gt && chain[CAPACITY].hit_eq;
        edit = EDIT_DELETE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.opcode = op_r;
    ctrl.value  = value_r;
    ctrl.edit   = (commit && ok) ? edit : EDIT_NONE;
  end

  always_comb begin
    used_nxt = used_r;
    if (ok) begin
      if (edit == EDIT_DELETE) used_nxt = used_r - UW'(1);
      else used_nxt = used_r + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_data.opcode;
      value_r <= in_data.value;
    end
    if (commit) begin
      out_data_r.ok        <= ok;
      out_data_r.count     <= COUNT_W'(used_nxt);
      out_data_r.empty_res <= (used_nxt == '0);
      out_data_r.full_res  <= (used_nxt == UW'(CAPACITY));
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_entry = ent[i];
    end else begin : g_body_l
      assign left_entry = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = ent[i];
    end else begin : g_body_r
      assign right_entry = ent[i+1];
    end

    bsl_cell #(
      .IDX (i),
      .UW  (UW)
    ) u_cell (
      .clk         (clk),
      .flag_en     (accept),
      .cmp_value   (in_data.value),
      .ctrl        (ctrl),
      .used        (used_r),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .entry       (ent[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_data_r.count == COUNT_W'(used_r))
    else $error("result count disagrees with held count");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !ok) |=> $stable(used_r))
    else $error("failed operation changed the count");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && empty &&
     (op_r == OP_REMOVE_FIRST || op_r == OP_SORTED_REMOVE)) |-> !ok)
    else $error("removal from empty list reported success");

endmodule
